// File: hw/rtl/imsi_pseudonym_table_defines.svh
// Assertion macros for the IMSI pseudonym table.
`ifndef IMSI_PSEUDONYM_TABLE_DEFINES_SVH
`define IMSI_PSEUDONYM_TABLE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define IPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define IPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define IPT_ASSERT_SAME(label, ante, cons, msg)

`define IPT_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/ipt_pkg.sv
package ipt_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
    localparam int COUNT_W       = ADDR_W + 1;

    localparam int MAX_DIGITS    = 15;
    localparam int NUM_W         = 4;
    localparam int NUM_LENGTHS   = 16;
    localparam int DIGIT_W       = 4 * MAX_DIGITS;
    localparam int KEY_W         = DIGIT_W + NUM_W;

    localparam int CTR_DIGITS    = 16;
    localparam int CTR_W         = 4 * CTR_DIGITS;
    localparam int CTR_LEN_W     = 5;

    localparam int PREFIX_W      = 24;
    localparam int PLEN_W        = 3;
    localparam int PREFIX_MAX    = 6;
    localparam logic [PLEN_W-1:0] PREFIX_LENGTH_RESET = 3'd5;

    localparam int CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_DIGITS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LENGTH = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LOAD,
        ST_CALC,
        ST_BUILD,
        ST_STORE
    } ipt_state_t;

    function automatic logic [DIGIT_W-1:0] digit_mask(input logic [NUM_W-1:0] n);
        logic [DIGIT_W-1:0] m;
        m = '0;
        for (int j = 0; j < MAX_DIGITS; j++) begin
            if (j < int'(n)) begin
                m[(MAX_DIGITS-1-j)*4 +: 4] = 4'hF;
            end
        end
        return m;
    endfunction

    function automatic logic [CTR_LEN_W-1:0] bcd_width(input logic [CTR_W-1:0] v);
        logic [CTR_LEN_W-1:0] w;
        w = CTR_LEN_W'(1);
        for (int k = 1; k < CTR_DIGITS; k++) begin
            if (v[k*4 +: 4] != 4'h0) begin
                w = CTR_LEN_W'(k + 1);
            end
        end
        return w;
    endfunction

endpackage

// File: hw/rtl/imsi_pseudonym_table.sv
// IMSI pseudonym table. Pulse start while busy is low to present an IMSI; busy
// stays high until the answer is produced, and done is high for exactly one
// cycle with the pseudonym and flags. The receiver cannot stall, so done must
// be captured when it is seen. A lookup walks the stored entries one per cycle
// through the read port of the key memory, so the number of stored entries sets
// the time. An IMSI found in the table answers from the walk; a new IMSI goes
// through the walk, the counter load, the width compare, a build loop over the
// 16 counter digits (one per cycle, whatever the IMSI length), the store and
// the cycle in which done is high. busy is already low while done is high, so
// the next IMSI may be taken in that cycle. Configuration transfers are always
// taken and should only be made while idle.
`include "imsi_pseudonym_table_defines.svh"

module imsi_pseudonym_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ipt_pkg::DIGIT_W-1:0]         subscriber_digits,
    input  logic [ipt_pkg::NUM_W-1:0]           digit_count,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ipt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ipt_pkg::PREFIX_W-1:0]        cfg_data,
    output logic                                done,
    output logic [ipt_pkg::DIGIT_W-1:0]         pseudonym_digits,
    output logic                                was_known,
    output logic                                counter_overflow,
    output logic                                table_full
);

    ipt_pkg::ipt_state_t state_reg, state_next;

    logic [ipt_pkg::KEY_W-1:0]     key_mem [ipt_pkg::TABLE_ENTRIES];
    logic [ipt_pkg::DIGIT_W-1:0]   pseu_mem [ipt_pkg::TABLE_ENTRIES];

    logic [ipt_pkg::PREFIX_W-1:0]  prefix_digits_reg;
    logic [ipt_pkg::PLEN_W-1:0]    prefix_length_reg;

    logic [ipt_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [ipt_pkg::COUNT_W-1:0]   addr_reg, addr_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic [ipt_pkg::KEY_W-1:0]     key_rd_reg;
    logic [ipt_pkg::DIGIT_W-1:0]   pseu_rd_reg;
    logic [ipt_pkg::COUNT_W-1:0]   entry_count_reg, entry_count_next;
    logic [ipt_pkg::CTR_W-1:0]     len_ctr_reg [ipt_pkg::NUM_LENGTHS];
    logic [ipt_pkg::CTR_W-1:0]     counter_reg, counter_next;
    logic [ipt_pkg::CTR_W-1:0]     inc_reg, inc_next;
    logic                          carry_reg, carry_next;
    logic [ipt_pkg::CTR_LEN_W-1:0] width_reg, width_next;
    logic                          ovf_reg, ovf_next;
    logic [ipt_pkg::NUM_W-1:0]     pos_reg, pos_next;
    logic [ipt_pkg::DIGIT_W-1:0]   result_reg, result_next;

    logic                          done_reg, done_next;
    logic [ipt_pkg::DIGIT_W-1:0]   out_digits_reg, out_digits_next;
    logic                          known_reg, known_next;
    logic                          out_ovf_reg, out_ovf_next;
    logic                          full_reg, full_next;

    logic                          rd_en;
    logic                          hit;
    logic                          mem_we;
    logic                          ctr_we;
    logic [ipt_pkg::NUM_W-1:0]     n_sat;
    logic [ipt_pkg::NUM_W-1:0]     key_len;
    logic [ipt_pkg::PLEN_W-1:0]    p_sat;
    logic [ipt_pkg::NUM_W-1:0]     rem;
    logic [ipt_pkg::CTR_LEN_W-1:0] cnt_width;
    logic [ipt_pkg::PLEN_W-1:0]    pidx;
    logic [5:0]                    kidx;
    logic [3:0]                    nib;
    logic [3:0]                    inc_digit;

    assign busy      = (state_reg != ipt_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    assign done             = done_reg;
    assign pseudonym_digits = out_digits_reg;
    assign was_known        = known_reg;
    assign counter_overflow = out_ovf_reg;
    assign table_full       = full_reg;

    assign n_sat   = (digit_count > ipt_pkg::NUM_W'(ipt_pkg::MAX_DIGITS))
                   ? ipt_pkg::NUM_W'(ipt_pkg::MAX_DIGITS) : digit_count;
    assign key_len = key_reg[ipt_pkg::KEY_W-1 -: ipt_pkg::NUM_W];
    assign p_sat   = (prefix_length_reg > ipt_pkg::PLEN_W'(ipt_pkg::PREFIX_MAX))
                   ? ipt_pkg::PLEN_W'(ipt_pkg::PREFIX_MAX) : prefix_length_reg;
    assign rem     = (key_len > {1'b0, p_sat}) ? (key_len - {1'b0, p_sat}) : '0;
    assign cnt_width = ipt_pkg::bcd_width(counter_reg);

    assign rd_en  = (state_reg == ipt_pkg::ST_SEARCH) && (addr_reg < entry_count_reg);
    assign hit    = rd_valid_reg && (key_rd_reg == key_reg);
    assign mem_we = (state_reg == ipt_pkg::ST_STORE)
                 && (entry_count_reg < ipt_pkg::COUNT_W'(ipt_pkg::TABLE_ENTRIES));
    assign ctr_we = (state_reg == ipt_pkg::ST_STORE);

    assign pidx = ipt_pkg::PLEN_W'(ipt_pkg::PREFIX_MAX - 1) - pos_reg[ipt_pkg::PLEN_W-1:0];
    assign kidx = 6'(width_reg) + 6'(p_sat) - 6'd1 - 6'(pos_reg);
    assign inc_digit = inc_reg[pos_reg*4 +: 4];

    always_comb
    begin
        if ({1'b0, pos_reg} < 5'(p_sat)) begin
            nib = prefix_digits_reg[pidx*4 +: 4];
        end else begin
            nib = counter_reg[kidx[3:0]*4 +: 4];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ipt_pkg::ST_IDLE:
            begin
                if (start) begin
                    state_next = ipt_pkg::ST_SEARCH;
                end
            end
            ipt_pkg::ST_SEARCH:
            begin
                if (hit) begin
                    state_next = ipt_pkg::ST_IDLE;
                end else if (!rd_valid_reg && !rd_en) begin
                    state_next = ipt_pkg::ST_LOAD;
                end
            end
            ipt_pkg::ST_LOAD:  state_next = ipt_pkg::ST_CALC;
            ipt_pkg::ST_CALC:  state_next = ipt_pkg::ST_BUILD;
            ipt_pkg::ST_BUILD:
            begin
                if (pos_reg == ipt_pkg::NUM_W'(ipt_pkg::CTR_DIGITS - 1)) begin
                    state_next = ipt_pkg::ST_STORE;
                end
            end
            ipt_pkg::ST_STORE: state_next = ipt_pkg::ST_IDLE;
            default:           state_next = ipt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        key_next         = key_reg;
        addr_next        = addr_reg;
        rd_valid_next    = 1'b0;
        entry_count_next = entry_count_reg;
        counter_next     = counter_reg;
        inc_next         = inc_reg;
        carry_next       = carry_reg;
        width_next       = width_reg;
        ovf_next         = ovf_reg;
        pos_next         = pos_reg;
        result_next      = result_reg;
        done_next        = 1'b0;
        out_digits_next  = out_digits_reg;
        known_next       = known_reg;
        out_ovf_next     = out_ovf_reg;
        full_next        = full_reg;
        case (state_reg)
            ipt_pkg::ST_IDLE:
            begin
                if (start) begin
                    key_next  = {n_sat, subscriber_digits & ipt_pkg::digit_mask(n_sat)};
                    addr_next = '0;
                end
            end
            ipt_pkg::ST_SEARCH:
            begin
                if (rd_en) begin
                    addr_next     = addr_reg + 1'b1;
                    rd_valid_next = 1'b1;
                end
                if (hit) begin
                    rd_valid_next   = 1'b0;
                    done_next       = 1'b1;
                    out_digits_next = pseu_rd_reg;
                    known_next      = 1'b1;
                    out_ovf_next    = 1'b0;
                    full_next       = 1'b0;
                end
            end
            ipt_pkg::ST_LOAD:
            begin
                counter_next = len_ctr_reg[key_len];
                inc_next     = len_ctr_reg[key_len];
                carry_next   = 1'b1;
                pos_next     = '0;
                result_next  = '0;
            end
            ipt_pkg::ST_CALC:
            begin
                width_next = (cnt_width > ipt_pkg::CTR_LEN_W'(rem))
                           ? cnt_width : ipt_pkg::CTR_LEN_W'(rem);
                ovf_next   = (cnt_width > ipt_pkg::CTR_LEN_W'(rem));
            end
            ipt_pkg::ST_BUILD:
            begin
                if (pos_reg < key_len) begin
                    result_next[(ipt_pkg::MAX_DIGITS-1-int'(pos_reg))*4 +: 4] = nib;
                end
                if (carry_reg) begin
                    if (inc_digit < 4'd9) begin
                        inc_next[pos_reg*4 +: 4] = inc_digit + 4'd1;
                        carry_next = 1'b0;
                    end else begin
                        inc_next[pos_reg*4 +: 4] = 4'd0;
                    end
                end
                pos_next = pos_reg + 1'b1;
            end
            ipt_pkg::ST_STORE:
            begin
                if (mem_we) begin
                    entry_count_next = entry_count_reg + 1'b1;
                end
                done_next       = 1'b1;
                out_digits_next = result_reg;
                known_next      = 1'b0;
                out_ovf_next    = ovf_reg;
                full_next       = !mem_we;
            end
            default:
            begin
                rd_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg         <= ipt_pkg::ST_IDLE;
            rd_valid_reg      <= 1'b0;
            entry_count_reg   <= '0;
            done_reg          <= 1'b0;
            prefix_digits_reg <= '0;
            prefix_length_reg <= ipt_pkg::PREFIX_LENGTH_RESET;
            for (int i = 0; i < ipt_pkg::NUM_LENGTHS; i++) begin
                len_ctr_reg[i] <= '0;
            end
        end else begin
            state_reg       <= state_next;
            rd_valid_reg    <= rd_valid_next;
            entry_count_reg <= entry_count_next;
            done_reg        <= done_next;
            if (ctr_we) begin
                len_ctr_reg[key_len] <= inc_reg;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ipt_pkg::CFG_PREFIX_DIGITS: prefix_digits_reg <= cfg_data;
                    ipt_pkg::CFG_PREFIX_LENGTH:
                    begin
                        prefix_length_reg <= cfg_data[ipt_pkg::PLEN_W-1:0];
                    end
                    default:
                    begin
                        prefix_length_reg <= prefix_length_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        addr_reg       <= addr_next;
        counter_reg    <= counter_next;
        inc_reg        <= inc_next;
        carry_reg      <= carry_next;
        width_reg      <= width_next;
        ovf_reg        <= ovf_next;
        pos_reg        <= pos_next;
        result_reg     <= result_next;
        out_digits_reg <= out_digits_next;
        known_reg      <= known_next;
        out_ovf_reg    <= out_ovf_next;
        full_reg       <= full_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            key_mem[entry_count_reg[ipt_pkg::ADDR_W-1:0]]  <= key_reg;
            pseu_mem[entry_count_reg[ipt_pkg::ADDR_W-1:0]] <= result_reg;
        end
        if (rd_en) begin
            key_rd_reg  <= key_mem[addr_reg[ipt_pkg::ADDR_W-1:0]];
            pseu_rd_reg <= pseu_mem[addr_reg[ipt_pkg::ADDR_W-1:0]];
        end
    end

    `IPT_ASSERT_SAME(a_done_when_idle, done, !busy, "result strobe while busy")
    `IPT_ASSERT_SAME(a_count_bound, 1'b1,
        entry_count_reg <= ipt_pkg::COUNT_W'(ipt_pkg::TABLE_ENTRIES),
        "entry count past table size")
    `IPT_ASSERT_NEXT(a_store_gives_result, state_reg == ipt_pkg::ST_STORE,
        done && !was_known, "new entry without result")
    `IPT_ASSERT_SAME(a_known_flags, done && was_known,
        !counter_overflow && !table_full, "flags set on known entry")

endmodule

// File: verif/tb_top.sv
module tb_top;

    typedef logic [ipt_pkg::DIGIT_W-1:0] digits_t;

    typedef struct packed {
        digits_t digits;
        logic    known;
        logic    overflow;
        logic    full;
    } pseudonym_answer_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    digits_t                         subscriber_digits = '0;
    logic [ipt_pkg::NUM_W-1:0]       digit_count = '0;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [ipt_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ipt_pkg::PREFIX_W-1:0]    cfg_data = '0;
    logic                            done;
    digits_t                         pseudonym_digits;
    logic                            was_known;
    logic                            counter_overflow;
    logic                            table_full;

    logic [ipt_pkg::PREFIX_W-1:0]    cur_prefix = '0;
    logic [ipt_pkg::PLEN_W-1:0]      cur_prefix_len = ipt_pkg::PREFIX_LENGTH_RESET;
    logic [63:0]                     known_keys [ipt_pkg::TABLE_ENTRIES];
    digits_t                         known_pseudonyms [ipt_pkg::TABLE_ENTRIES];
    int                              stored_pairs = 0;
    logic [63:0]                     length_counter [16];

    logic [63:0]                     seen_ids [$];
    pseudonym_answer_t               answers_due [$];

    int mismatches = 0;
    int n_sent = 0;
    int n_known = 0;
    int n_fresh = 0;
    int n_refused = 0;
    int n_cut = 0;
    int n_settings = 1;

    imsi_pseudonym_table u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .subscriber_digits (subscriber_digits),
        .digit_count       (digit_count),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .done              (done),
        .pseudonym_digits  (pseudonym_digits),
        .was_known         (was_known),
        .counter_overflow  (counter_overflow),
        .table_full        (table_full)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic digits_t nibble_mask(input int n);
        digits_t m;
        m = '0;
        for (int j = 0; j < n; j++)
            m[56-4*j +: 4] = 4'hF;
        return m;
    endfunction

    function automatic logic [63:0] bcd_next(input logic [63:0] v);
        logic [63:0] r;
        logic        carry;
        r = v;
        carry = 1'b1;
        for (int k = 0; k < 16; k++)
        begin
            if (carry)
            begin
                if (r[4*k +: 4] < 4'd9)
                begin
                    r[4*k +: 4] = r[4*k +: 4] + 4'd1;
                    carry = 1'b0;
                end
                else
                    r[4*k +: 4] = 4'd0;
            end
        end
        return r;
    endfunction

    function automatic int dec_width(input logic [63:0] v);
        int w;
        w = 1;
        for (int k = 1; k < 16; k++)
            if (v[4*k +: 4] != 4'd0)
                w = k + 1;
        return w;
    endfunction

    function automatic pseudonym_answer_t lookup_or_assign(input digits_t d,
                                                           input logic [3:0] cnt);
        pseudonym_answer_t a;
        logic [63:0]       key;
        logic [63:0]       ctr;
        int                n;
        int                p;
        int                rem;
        int                dw;
        int                w;
        int                k;
        n = int'(cnt);
        p = (cur_prefix_len > 3'd6) ? 6 : int'(cur_prefix_len);
        key = {cnt, d & nibble_mask(n)};
        a = '0;
        for (int i = 0; i < stored_pairs; i++)
        begin
            if (known_keys[i] == key)
            begin
                a.digits = known_pseudonyms[i];
                a.known = 1'b1;
                return a;
            end
        end
        ctr = length_counter[n];
        rem = (n > p) ? n - p : 0;
        dw = dec_width(ctr);
        w = (dw > rem) ? dw : rem;
        a.overflow = (dw > rem);
        for (int i = 0; i < n; i++)
        begin
            if (i < p)
                a.digits[56-4*i +: 4] = cur_prefix[20-4*i +: 4];
            else
            begin
                k = w - 1 - (i - p);
                a.digits[56-4*i +: 4] = ctr[4*k +: 4];
            end
        end
        if (stored_pairs < ipt_pkg::TABLE_ENTRIES)
        begin
            known_keys[stored_pairs] = key;
            known_pseudonyms[stored_pairs] = a.digits;
            stored_pairs++;
        end
        else
            a.full = 1'b1;
        length_counter[n] = bcd_next(ctr);
        return a;
    endfunction

    function automatic digits_t make_imsi(input int n);
        digits_t v;
        for (int j = 0; j < 15; j++)
            v[56-4*j +: 4] = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                          : 4'($urandom_range(0, 9));
        if ($urandom_range(0, 3) != 0)
            v = v & nibble_mask(n);
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 24);
        return $urandom_range(40, 320);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task automatic send_imsi(input digits_t d, input logic [3:0] n, input bit hold);
        pseudonym_answer_t a;
        logic [63:0]       id;
        subscriber_digits <= d;
        digit_count <= n;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        a = lookup_or_assign(d, n);
        answers_due = {answers_due, a};
        id = {n, d & nibble_mask(int'(n))};
        seen_ids = {seen_ids, id};
        n_sent++;
        if (a.known)
            n_known++;
        else
            n_fresh++;
        if (a.full)
            n_refused++;
        if (a.overflow)
            n_cut++;
        if (!hold)
            start <= 1'b0;
    endtask

    task automatic send_then_gap(input digits_t d, input logic [3:0] n, input bit burst);
        int gap;
        gap = burst ? 0 : pick_gap();
        send_imsi(d, n, gap == 0);
        repeat (gap)
            @(posedge clk);
    endtask

    task automatic wait_until_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (answers_due.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic program_prefix(input logic [23:0] prefix, input logic [2:0] plen);
        cfg_index <= ipt_pkg::CFG_PREFIX_DIGITS;
        cfg_data <= prefix;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_prefix = prefix;
        cfg_index <= ipt_pkg::CFG_PREFIX_LENGTH;
        cfg_data <= {21'd0, plen};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cur_prefix_len = plen;
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic test_default_prefix();
        send_then_gap({15{4'h9}}, 4'd15, 1'b0);
        send_then_gap('0, 4'd15, 1'b0);
        send_then_gap({4'h5, {14{4'hF}}}, 4'd1, 1'b0);
        send_then_gap({15{4'hF}}, 4'd0, 1'b0);
        send_then_gap({15{4'h3}}, 4'd0, 1'b0);
        send_then_gap(60'h123450000000000, 4'd5, 1'b0);
        send_then_gap({15{4'h9}}, 4'd15, 1'b0);
        send_then_gap(60'hABCDEF0123_77777, 4'd10, 1'b0);
        send_then_gap(60'hABCDEF0123_00000, 4'd10, 1'b0);
    endtask

    task automatic test_prefix_extremes();
        wait_until_quiet();
        program_prefix(24'h999999, 3'd6);
        send_then_gap(60'h123456000000000, 4'd6, 1'b0);
        send_then_gap(make_imsi(15), 4'd15, 1'b0);
        send_then_gap(60'h987654321000000, 4'd7, 1'b0);
        wait_until_quiet();
        program_prefix(24'h4AFB3C, 3'd7);
        send_then_gap(60'hFEDCBA987654321, 4'd15, 1'b0);
        send_then_gap(60'h555000000000000, 4'd3, 1'b0);
        wait_until_quiet();
        program_prefix(24'h000000, 3'd0);
        send_then_gap(60'h000000000000001, 4'd15, 1'b0);
        send_then_gap(60'h700000000000000, 4'd1, 1'b0);
        send_then_gap({15{4'h9}}, 4'd15, 1'b0);
    endtask

    task automatic test_random_traffic(input int items);
        logic [63:0] id;
        digits_t     d;
        logic [3:0]  n;
        int          per_phase;
        per_phase = items / 4;
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_until_quiet();
            case (ph)
                0: program_prefix(24'h999999, 3'd6);
                1: program_prefix(24'h000000, 3'd0);
                default: program_prefix(24'($urandom_range(0, 24'h999999)),
                                        3'($urandom_range(0, 7)));
            endcase
            for (int k = 0; k < per_phase; k++)
            begin
                if (seen_ids.size() != 0 && $urandom_range(0, 99) < 60)
                begin
                    id = seen_ids[$urandom_range(0, seen_ids.size() - 1)];
                    n = id[63:60];
                    d = id[59:0];
                    if ($urandom_range(0, 1) == 1)
                        d = d | (make_imsi(15) & ~nibble_mask(int'(n)));
                end
                else
                begin
                    n = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(5, 8))
                                                    : 4'($urandom_range(0, 15));
                    d = make_imsi(int'(n));
                end
                send_then_gap(d, n, (k % 150) < 30);
            end
        end
    endtask

    always @(posedge clk)
    begin
        pseudonym_answer_t want;
        if (rst_n && done === 1'b1)
        begin
            if (answers_due.size() == 0)
                report_mismatch("result with nothing outstanding", 64'(pseudonym_digits), '0);
            else
            begin
                want = answers_due.pop_front();
                if (pseudonym_digits !== want.digits)
                    report_mismatch("pseudonym_digits", 64'(pseudonym_digits),
                                    64'(want.digits));
                if (was_known !== want.known)
                    report_mismatch("was_known", 64'(was_known), 64'(want.known));
                if (counter_overflow !== want.overflow)
                    report_mismatch("counter_overflow", 64'(counter_overflow),
                                    64'(want.overflow));
                if (table_full !== want.full)
                    report_mismatch("table_full", 64'(table_full), 64'(want.full));
            end
        end
    end

    initial
    begin
        #(4 * 3000000);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        foreach (length_counter[i])
            length_counter[i] = '0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_prefix();
        test_prefix_extremes();
        test_random_traffic(1080);
        wait_until_quiet();
        repeat (300)
            @(posedge clk);
        $display("Sent %0d IMSIs under %0d prefix settings: %0d answered from the table, %0d new.",
                 n_sent, n_settings, n_known, n_fresh);
        $display("New IMSIs refused by a full table: %0d; pseudonyms with the counter cut: %0d.",
                 n_refused, n_cut);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
